[rtl/core/affine_transform_accumulator_defines.svh]
// Assertion macros used by the transform accumulator controller RTL.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_DEFINES_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ATA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define ATA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/core/atacc_pkg.sv]
// Package: shared types, codes and the CORDIC angle table.
`default_nettype none
package atacc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int STEP_W = 5;

  localparam logic [2:0] ACT_IDENTITY  = 3'd0;
  localparam logic [2:0] ACT_TRANSLATE = 3'd1;
  localparam logic [2:0] ACT_SCALE     = 3'd2;
  localparam logic [2:0] ACT_ROTATE    = 3'd3;
  localparam logic [2:0] ACT_READ      = 3'd4;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [63:0] RAD_IN_DEG24 = 64'd961263669;

  typedef struct packed {
    logic              load_in;
    logic              load_id;
    logic              build_r;
    logic              cordic_init;
    logic              cordic_step;
    logic              build_rot;
    logic              mac;
    logic              commit;
    logic              out_load;
    logic [5:0]        cnt;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic [1:0] axis;
    logic       out_free;
  } stat_t;

  // atan(2^-i) in degrees scaled by 2^24
  function automatic logic signed [35:0] atan_deg24(input logic [STEP_W-1:0] i);
    logic [63:0] tmp;
    tmp = 64'd0;
    case (i)
      5'd0:  atan_deg24 = 36'sd754974720;
      5'd1:  atan_deg24 = 36'sd445687602;
      5'd2:  atan_deg24 = 36'sd235489088;
      5'd3:  atan_deg24 = 36'sd119537938;
      5'd4:  atan_deg24 = 36'sd60000934;
      5'd5:  atan_deg24 = 36'sd30029717;
      5'd6:  atan_deg24 = 36'sd15018523;
      5'd7:  atan_deg24 = 36'sd7509720;
      5'd8:  atan_deg24 = 36'sd3754917;
      5'd9:  atan_deg24 = 36'sd1877466;
      5'd10: atan_deg24 = 36'sd938734;
      5'd11: atan_deg24 = 36'sd469367;
      default: begin
        tmp = RAD_IN_DEG24 + (64'd1 << (i - 5'd1));
        atan_deg24 = 36'(tmp >> i);
      end
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/core/atacc_ctrl.sv]
// Controller: sequences decode, CORDIC iterations, MAC sweep, commit and readout.
`default_nettype none
`include "affine_transform_accumulator_defines.svh"
module atacc_ctrl #(
  parameter int CORDIC_STEPS = atacc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire atacc_pkg::stat_t stat,
  output atacc_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DEC    = 3'd1;
  localparam logic [2:0] ST_CORD   = 3'd2;
  localparam logic [2:0] ST_ROTR   = 3'd3;
  localparam logic [2:0] ST_MAC    = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_COMMIT = 3'd6;
  localparam logic [2:0] ST_READ   = 3'd7;

  localparam logic [atacc_pkg::STEP_W-1:0] LAST_STEP = atacc_pkg::STEP_W'(CORDIC_STEPS - 1);

  logic [2:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [atacc_pkg::STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    step_next  = step;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.cnt    = cnt;
    cmd.step   = step;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DEC;
        end
      end
      ST_DEC: begin
        cnt_next  = '0;
        step_next = '0;
        case (stat.action)
          atacc_pkg::ACT_IDENTITY: begin
            cmd.load_id = 1'b1;
            state_next  = ST_IDLE;
          end
          atacc_pkg::ACT_TRANSLATE, atacc_pkg::ACT_SCALE: begin
            cmd.build_r = 1'b1;
            state_next  = ST_MAC;
          end
          atacc_pkg::ACT_ROTATE: begin
            if (stat.axis == atacc_pkg::AXIS_NONE) begin
              state_next = ST_IDLE;
            end else begin
              cmd.cordic_init = 1'b1;
              state_next      = ST_CORD;
            end
          end
          atacc_pkg::ACT_READ: state_next = ST_READ;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_CORD: begin
        cmd.cordic_step = 1'b1;
        if (step == LAST_STEP) begin
          state_next = ST_ROTR;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_ROTR: begin
        cmd.build_rot = 1'b1;
        cnt_next      = '0;
        state_next    = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac  = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == 6'd63) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_COMMIT;
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cnt_next     = cnt + 1'b1;
          if (cnt[3:0] == 4'd15) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ATA_ASSERT_NXT(a_mac_drain, clk, rst, state == ST_MAC && cnt == 6'd63, state == ST_DRAIN)
  `ATA_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, state == ST_READ && stat.out_free)
  `ATA_ASSERT_NXT(a_commit_idle, clk, rst, cmd.commit, state == ST_IDLE && !cmd.mac)

endmodule
`default_nettype wire

[rtl/core/atacc_dpath.sv]
// Datapath: matrix registers, action matrix, CORDIC unit, shared MAC, output register.
`default_nettype none
module atacc_dpath #(
  parameter int FRACTION_BITS = atacc_pkg::FRACTION_BITS_DEF,
  parameter int ELEMENT_WIDTH = atacc_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [127:0]     s_tdata,
  input  wire logic [4:0]       s_tuser,
  output logic [39:0]           m_tdata,
  output logic                  m_tlast,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire atacc_pkg::cmd_t  cmd,
  output atacc_pkg::stat_t      stat
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * EW + 1;
  localparam int AW = 2 * EW + 3;
  localparam int S  = 30 - F;

  localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [65:0] EMAX_W = 66'(EMAX);
  localparam logic signed [65:0] EMIN_W = 66'(EMIN);
  localparam logic signed [EW-1:0] ONE = (F >= EW - 1) ? EMAX : EW'(64'd1 << F);
  localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (F - 1));
  localparam logic signed [35:0] QRND = (S > 0) ? (36'sd1 <<< ((S > 0) ? S - 1 : 0)) : 36'sd0;
  localparam logic signed [65:0] I32MAX = 66'sd2147483647;
  localparam logic signed [65:0] I32MIN = -66'sd2147483648;

  localparam logic signed [27:0] D90  = 28'sd5898240;
  localparam logic signed [27:0] D180 = 28'sd11796480;
  localparam logic signed [27:0] D360 = 28'sd23592960;

  function automatic logic signed [EW-1:0] clamp66(input logic signed [65:0] w);
    if (w > EMAX_W) clamp66 = EMAX;
    else if (w < EMIN_W) clamp66 = EMIN;
    else clamp66 = EW'(w);
  endfunction

  function automatic logic signed [EW-1:0] sat_acc(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] mx, mn;
    mx = AW'(EMAX);
    mn = AW'(EMIN);
    if (a > mx) sat_acc = EMAX;
    else if (a < mn) sat_acc = EMIN;
    else sat_acc = EW'(a);
  endfunction

  logic signed [EW-1:0] mat [16];
  logic signed [EW-1:0] res [16];
  logic signed [EW:0]   rmat [16];
  logic signed [EW:0]   rmat_new [16];

  logic [2:0] action;
  logic [1:0] axis;
  logic signed [EW-1:0] opx, opy, opz;
  logic signed [25:0] angle;

  logic signed [33:0] cx, cy;
  logic signed [35:0] cz;
  logic               flip;

  logic signed [PW-1:0] prod;
  logic                 tag_v, tag_first, tag_last;
  logic [3:0]           tag_idx;
  logic signed [AW-1:0] acc;

  logic out_valid;

  assign stat.action   = action;
  assign stat.axis     = axis;
  assign stat.out_free = !out_valid || m_tready;
  assign m_tvalid      = out_valid;

  // angle wrap into +-180 then fold into +-90
  logic signed [27:0] deg_w, deg_f;
  logic               fold;
  always_comb begin
    deg_w = 28'(angle);
    if (deg_w > D180) deg_w = deg_w - D360;
    if (deg_w < -D180) deg_w = deg_w + D360;
    fold  = 1'b0;
    deg_f = deg_w;
    if (deg_w > D90) begin
      deg_f = D180 - deg_w;
      fold  = 1'b1;
    end
    if (deg_w < -D90) begin
      deg_f = -D180 - deg_w;
      fold  = 1'b1;
    end
  end

  logic signed [33:0] dx, dy;
  logic signed [35:0] at;
  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;
  assign at = atacc_pkg::atan_deg24(cmd.step);

  // CORDIC results down to element format
  logic signed [35:0] xr, yr;
  logic signed [EW-1:0] sn, cs;
  logic signed [EW:0] snr, nsnr, csr;
  always_comb begin
    xr   = (36'(cx) + QRND) >>> S;
    yr   = (36'(cy) + QRND) >>> S;
    sn   = clamp66(66'(yr));
    cs   = clamp66(66'(xr));
    snr  = (EW+1)'(sn);
    nsnr = -snr;
    csr  = flip ? -((EW+1)'(cs)) : (EW+1)'(cs);
  end

  // action matrix: identity base, then the entries the action sets
  always_comb begin
    for (int n = 0; n < 16; n++) rmat_new[n] = (n % 5 == 0) ? (EW+1)'(ONE) : '0;
    if (cmd.build_rot) begin
      case (axis)
        atacc_pkg::AXIS_X: begin
          rmat_new[5] = csr; rmat_new[6] = snr; rmat_new[9] = nsnr; rmat_new[10] = csr;
        end
        atacc_pkg::AXIS_Y: begin
          rmat_new[0] = csr; rmat_new[2] = nsnr; rmat_new[8] = snr; rmat_new[10] = csr;
        end
        default: begin
          rmat_new[0] = csr; rmat_new[1] = snr; rmat_new[4] = nsnr; rmat_new[5] = csr;
        end
      endcase
    end else if (action == atacc_pkg::ACT_TRANSLATE) begin
      rmat_new[12] = (EW+1)'(opx);
      rmat_new[13] = (EW+1)'(opy);
      rmat_new[14] = (EW+1)'(opz);
    end else begin
      rmat_new[0]  = (EW+1)'(opx);
      rmat_new[5]  = (EW+1)'(opy);
      rmat_new[10] = (EW+1)'(opz);
    end
  end

  logic signed [PW-1:0] rp;
  logic signed [AW-1:0] acc_new;
  always_comb begin
    rp      = (prod + HALF) >>> F;
    acc_new = tag_first ? AW'(rp) : acc + AW'(rp);
  end

  logic signed [EW-1:0] rd_elem;
  assign rd_elem = mat[cmd.cnt[3:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < 16; n++) mat[n] <= (n % 5 == 0) ? ONE : '0;
      tag_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_id) begin
        for (int n = 0; n < 16; n++) mat[n] <= (n % 5 == 0) ? ONE : '0;
      end
      if (cmd.commit) begin
        for (int n = 0; n < 16; n++) mat[n] <= res[n];
      end
      tag_v <= cmd.mac;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action <= s_tuser[2:0];
      axis   <= s_tuser[4:3];
      opx    <= clamp66(66'($signed(s_tdata[31:0])));
      opy    <= clamp66(66'($signed(s_tdata[63:32])));
      opz    <= clamp66(66'($signed(s_tdata[95:64])));
      angle  <= s_tdata[121:96];
    end
    if (cmd.build_r || cmd.build_rot) begin
      for (int n = 0; n < 16; n++) rmat[n] <= rmat_new[n];
    end
    if (cmd.cordic_init) begin
      cx   <= atacc_pkg::GAIN_INV_Q30;
      cy   <= '0;
      cz   <= 36'(deg_f) <<< 8;
      flip <= fold;
    end
    if (cmd.cordic_step) begin
      if (cz >= 0) begin
        cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
      end else begin
        cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
      end
    end
    // cnt = {j, i, k}
    if (cmd.mac) begin
      prod      <= PW'(mat[{cmd.cnt[1:0], cmd.cnt[3:2]}]) * PW'(rmat[{cmd.cnt[5:4], cmd.cnt[1:0]}]);
      tag_first <= (cmd.cnt[1:0] == 2'd0);
      tag_last  <= (cmd.cnt[1:0] == 2'd3);
      tag_idx   <= {cmd.cnt[5:4], cmd.cnt[3:2]};
    end
    if (tag_v) begin
      acc <= acc_new;
      if (tag_last) res[tag_idx] <= sat_acc(acc_new);
    end
    if (cmd.out_load) begin
      m_tdata[3:0]   <= cmd.cnt[3:0];
      m_tdata[39:36] <= '0;
      if (66'(rd_elem) > I32MAX) m_tdata[35:4] <= 32'h7fffffff;
      else if (66'(rd_elem) < I32MIN) m_tdata[35:4] <= 32'h80000000;
      else m_tdata[35:4] <= 32'(66'(rd_elem));
      m_tlast <= (cmd.cnt[3:0] == 4'd15);
    end
  end

endmodule
`default_nettype wire

[rtl/core/affine_transform_accumulator.sv]
// Top level: 4x4 fixed-point transform accumulator with stream ports.
//
//  port group  dir  fields (low bit up)
//  s_*         in   tdata: operand_x, operand_y, operand_z, angle_degrees; tuser: action, axis
//  m_*         out  tdata: element_index, element_value; tlast: last_element
//
// Identity reloads the matrix with no MAC sweep. Translate/scale: 64 MACs on the one multiplier.
// Rotate: one CORDIC iteration per cycle first, then the same MAC sweep.
// Read: 16 words, one per cycle while m_tready is high; a stalled word holds.
// s_tready is high only between actions; the last output word may still be waiting.
// Reset (rst, synchronous) loads identity into the matrix.
`default_nettype none
module affine_transform_accumulator #(
  parameter int FRACTION_BITS = atacc_pkg::FRACTION_BITS_DEF,
  parameter int ELEMENT_WIDTH = atacc_pkg::ELEMENT_WIDTH_DEF,
  parameter int CORDIC_STEPS  = atacc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // operand_x, operand_y, operand_z, angle_degrees, pad
  input  wire logic [4:0]   s_tuser,  // action, rotation_axis
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,  // element_index, element_value, pad
  output logic              m_tlast   // last_element
);

  atacc_pkg::cmd_t  cmd;
  atacc_pkg::stat_t stat;

  atacc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  atacc_dpath #(
    .FRACTION_BITS(FRACTION_BITS),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the 4x4 transform accumulator: directed cases, then random ones.
module tb;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] val;
    logic        last;
  } elem_word_t;

  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 200;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [4:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         m_tlast;

  affine_transform_accumulator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint     model_mat[16];
  elem_word_t readout_q[$];
  int         n_errors = 0;
  int         n_words = 0;
  int         n_items = 0;
  int         n_reads = 0;
  int         cycle_cnt = 0;

  // pacing knobs
  bit         steady_tx = 1'b0;
  bit         steady_rx = 1'b0;
  int         burst_left = 0;
  int         hold_cycles = 0;
  int         rx_stall_pct = 30;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 754974720;
      1: return 445687602;
      2: return 235489088;
      3: return 119537938;
      4: return 60000934;
      5: return 30029717;
      6: return 15018523;
      7: return 7509720;
      8: return 3754917;
      9: return 1877466;
      10: return 938734;
      11: return 469367;
      default: return (64'sd961263669 + (64'sd1 << (i - 1))) >>> i;
    endcase
  endfunction

  function automatic void set_identity(ref longint m[16]);
    for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 64'sd65536 : 64'sd0;
  endfunction

  function automatic void compose(input longint r[16]);
    longint nxt[16];
    longint acc, p;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          p = model_mat[i + 4 * k] * r[k + 4 * j];
          acc += (p + 64'sd32768) >>> 16;
        end
        nxt[i + 4 * j] = sat32(acc);
      end
    for (int i = 0; i < 16; i++) model_mat[i] = nxt[i];
  endfunction

  function automatic void sin_cos_deg(input longint deg, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    bit flip;
    flip = 1'b0;
    if (deg > (64'sd180 <<< 16)) deg -= 64'sd360 <<< 16;
    if (deg < -(64'sd180 <<< 16)) deg += 64'sd360 <<< 16;
    if (deg > (64'sd90 <<< 16)) begin
      deg = (64'sd180 <<< 16) - deg;
      flip = 1'b1;
    end
    if (deg < -(64'sd90 <<< 16)) begin
      deg = -(64'sd180 <<< 16) - deg;
      flip = 1'b1;
    end
    x = 64'sd652032874;
    y = 0;
    z = deg * 256;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    sn = sat32((y + 64'sd8192) >>> 14);
    cs = sat32((x + 64'sd8192) >>> 14);
    if (flip) cs = -cs;
  endfunction

  function automatic void apply_action(logic [2:0] act, logic [31:0] ox, logic [31:0] oy,
                                       logic [31:0] oz, logic [1:0] ax, logic [25:0] ang);
    longint r[16];
    longint sn, cs;
    elem_word_t w;
    set_identity(r);
    case (act)
      atacc_pkg::ACT_IDENTITY: set_identity(model_mat);
      atacc_pkg::ACT_TRANSLATE: begin
        r[12] = longint'($signed(ox));
        r[13] = longint'($signed(oy));
        r[14] = longint'($signed(oz));
        compose(r);
      end
      atacc_pkg::ACT_SCALE: begin
        r[0] = longint'($signed(ox));
        r[5] = longint'($signed(oy));
        r[10] = longint'($signed(oz));
        compose(r);
      end
      atacc_pkg::ACT_ROTATE: begin
        if (ax != atacc_pkg::AXIS_NONE) begin
          sin_cos_deg(longint'($signed(ang)), sn, cs);
          if (ax == atacc_pkg::AXIS_X) begin
            r[5] = cs; r[6] = sn; r[9] = -sn; r[10] = cs;
          end else if (ax == atacc_pkg::AXIS_Y) begin
            r[0] = cs; r[2] = -sn; r[8] = sn; r[10] = cs;
          end else begin
            r[0] = cs; r[1] = sn; r[4] = -sn; r[5] = cs;
          end
          compose(r);
        end
      end
      atacc_pkg::ACT_READ: begin
        n_reads++;
        for (int i = 0; i < 16; i++) begin
          w.idx = 4'(i);
          w.val = 32'(sat32(model_mat[i]));
          w.last = (i == 15);
          readout_q = {readout_q, w};
        end
      end
      default: ;
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_word(logic [2:0] act, logic [31:0] ox = 0, logic [31:0] oy = 0,
                           logic [31:0] oz = 0, logic [1:0] ax = atacc_pkg::AXIS_X,
                           logic [25:0] ang = 0);
    int gap;
    s_tvalid = 1'b1;
    s_tdata = {6'd0, ang, oz, oy, ox};
    s_tuser = {ax, act};
    do @(posedge clk); while (!s_tready);
    apply_action(act, ox, oy, oz, ax, ang);
    n_items++;
    @(negedge clk);
    if (!steady_tx) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 10);
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH word %0d: %s got 0x%0h expected 0x%0h", n_words, what, got, want);
    n_errors++;
  endtask

  // receiver pacing
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready = 1'b0;
    end else if (steady_rx) begin
      m_tready = 1'b1;
    end else begin
      m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (readout_q.size() == 0) begin
        report_mismatch("unexpected word", longint'(m_tdata), 0);
      end else begin
        elem_word_t w;
        w = readout_q.pop_front();
        if (m_tdata[3:0] !== w.idx) report_mismatch("element_index", m_tdata[3:0], w.idx);
        if (m_tdata[35:4] !== w.val) report_mismatch("element_value", m_tdata[35:4], w.val);
        if (m_tlast !== w.last) report_mismatch("last_element", m_tlast, w.last);
      end
      n_words++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h0001_0000 + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
      2: return 32'hFFFF_0000 + $urandom_range(0, 32'h0000_4000);
      3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      4: return 32'h0000_8000 + $urandom_range(0, 32'h0001_0000);
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
    endcase
  endfunction

  function automatic logic [25:0] rand_angle();
    return 26'($urandom_range(0, 47185920) - 23592960);
  endfunction

  task automatic test_identity_read();
    send_word(atacc_pkg::ACT_READ);
    send_word(atacc_pkg::ACT_SCALE, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_8000);
    send_word(atacc_pkg::ACT_IDENTITY);
    send_word(atacc_pkg::ACT_READ);
  endtask

  task automatic test_translate_scale();
    send_word(atacc_pkg::ACT_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000);
    send_word(atacc_pkg::ACT_READ);
    send_word(atacc_pkg::ACT_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000);
    send_word(atacc_pkg::ACT_READ);
    // saturation both ways
    send_word(atacc_pkg::ACT_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(atacc_pkg::ACT_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(atacc_pkg::ACT_READ);
    send_word(atacc_pkg::ACT_IDENTITY);
  endtask

  task automatic test_rotate();
    logic [25:0] angles[10] = '{26'd0, 26'(90 <<< 16), 26'(-90 <<< 16), 26'(180 <<< 16),
                                26'(-180 <<< 16), 26'd23592960, 26'(-23592960),
                                26'(135 <<< 16), 26'(-200 <<< 16), 26'h1FF_FFFF};
    for (int i = 0; i < 10; i++)
      send_word(atacc_pkg::ACT_ROTATE, 0, 0, 0, 2'(i % 3), angles[i]);
    send_word(atacc_pkg::ACT_ROTATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              atacc_pkg::AXIS_NONE, 26'(45 <<< 16));
    send_word(atacc_pkg::ACT_READ);
  endtask

  task automatic test_unknown_action();
    send_word(3'd5, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    send_word(3'd6);
    send_word(3'd7);
    send_word(atacc_pkg::ACT_READ);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    steady_tx = 1'b1;
    for (int i = 0; i < 4; i++) send_word(atacc_pkg::ACT_READ);
    steady_tx = 1'b0;
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 0) begin
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
        rx_stall_pct = $urandom_range(0, 80);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) act = atacc_pkg::ACT_IDENTITY;
      else if (pick < 28) act = atacc_pkg::ACT_TRANSLATE;
      else if (pick < 46) act = atacc_pkg::ACT_SCALE;
      else if (pick < 68) act = atacc_pkg::ACT_ROTATE;
      else if (pick < 97) act = atacc_pkg::ACT_READ;
      else act = 3'($urandom_range(5, 7));
      send_word(act, rand_operand(), rand_operand(), rand_operand(),
                2'($urandom_range(0, 3)), rand_angle());
    end
    steady_tx = 1'b0;
    steady_rx = 1'b0;
  endtask

  initial begin
    set_identity(model_mat);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_identity_read();
    test_translate_scale();
    test_rotate();
    test_unknown_action();
    test_backpressure();
    test_random(350);
    s_tvalid = 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d actions incl. %0d readouts; checked %0d matrix words in %0d cycles",
             n_items, n_reads, n_words, cycle_cnt);
    $display("Covered identity, translate, scale, rotations on all axes, saturation, backpressure");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/atacc_pkg.sv
rtl/core/atacc_ctrl.sv
rtl/core/atacc_dpath.sv
rtl/core/affine_transform_accumulator.sv
bench/tb.sv
